[src/lsh_pkg.sv]
package lsh_pkg;

	// channel and pixel geometry
	localparam int CHAN_W      = 8;
	localparam int CHAN_MAX    = 3;
	localparam int PIX_W       = CHAN_W * CHAN_MAX;
	localparam int CHANNELS    = 3;
	localparam int CENTRE_GAIN = 5;

	// frame geometry limits and reset values
	localparam int          ROW_W        = 12;
	localparam int          OUT_COL_W    = 11;
	localparam int          FW_W         = 12;
	localparam int          FH_W         = 13;
	localparam int          MIN_DIM      = 3;
	localparam int          MAX_HEIGHT   = 4096;
	localparam logic [11:0] RESET_WIDTH  = 12'd512;
	localparam logic [12:0] RESET_HEIGHT = 13'd512;

	// register map, one 32-bit word per register
	typedef enum logic {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] pixel_c2;
		logic [7:0] pixel_c1;
		logic [7:0] pixel_c0;
	} pix_t;

	typedef struct packed {
		logic [11:0] out_row;
		logic [10:0] out_col;
		logic [7:0]  out_c2;
		logic [7:0]  out_c1;
		logic [7:0]  out_c0;
		logic        run_end;
		logic        frame_end;
	} res_t;

	// 5*center minus the four cross neighbors, clamped to 0..255, per channel
	function automatic logic [PIX_W-1:0] sharpen(
		input logic [PIX_W-1:0] ctr,
		input logic [PIX_W-1:0] up,
		input logic [PIX_W-1:0] dn,
		input logic [PIX_W-1:0] lf,
		input logic [PIX_W-1:0] rt
	);
		logic [PIX_W-1:0]  res;
		logic signed [11:0] v;
		res = '0;
		for (int k = 0; k < CHAN_MAX; k++) begin
			v = $signed(12'(CENTRE_GAIN) * {4'b0, ctr[CHAN_W*k +: CHAN_W]}
				- {4'b0, up[CHAN_W*k +: CHAN_W]}
				- {4'b0, dn[CHAN_W*k +: CHAN_W]}
				- {4'b0, lf[CHAN_W*k +: CHAN_W]}
				- {4'b0, rt[CHAN_W*k +: CHAN_W]});
			if (k < CHANNELS) begin
				if (v < 0) begin
					res[CHAN_W*k +: CHAN_W] = '0;
				end else if (v > 12'sd255) begin
					res[CHAN_W*k +: CHAN_W] = '1;
				end else begin
					res[CHAN_W*k +: CHAN_W] = v[CHAN_W-1:0];
				end
			end
		end
		return res;
	endfunction

endpackage

[src/laplacian_sharpen_3x3.sv]
// 3x3 laplacian sharpening over a raster pixel stream, two rows of line storage
// a pixel passes stages 1, 2 and 3 before its first result beat is set in the output register
// throughput: one pixel per cycle while no pixel yields more than one beat and res_ready
//   holds; a pixel that yields more (last row, row ends) holds the pipe until all are taken
// reset: async, frame position, size and valid registers to defaults; line storage is
//   not cleared, rows 0 and 1 rewrite every entry before any read of it reaches a result
module laplacian_sharpen_3x3 #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	input  logic          pix_valid,
	output logic          pix_ready,
	input  lsh_pkg::pix_t pix,
	output logic          res_valid,
	input  logic          res_ready,
	output lsh_pkg::res_t res
);

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int WCAP = (MAX_WIDTH < 4095) ? MAX_WIDTH : 4095;
	localparam int PW   = lsh_pkg::PIX_W;

	logic [11:0] frame_width_q;
	logic [12:0] frame_height_q;
	logic        cfg_wr;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= lsh_pkg::RESET_WIDTH;
			frame_height_q <= lsh_pkg::RESET_HEIGHT;
		end else if (cfg_wr) begin
			case (lsh_pkg::reg_idx_t'(paddr[2]))
				lsh_pkg::REG_FRAME_WIDTH:  frame_width_q  <= pwdata[11:0];
				lsh_pkg::REG_FRAME_HEIGHT: frame_height_q <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (lsh_pkg::reg_idx_t'(paddr[2]))
			lsh_pkg::REG_FRAME_WIDTH:  prdata = {20'd0, frame_width_q};
			lsh_pkg::REG_FRAME_HEIGHT: prdata = {19'd0, frame_height_q};
			default:                   prdata = '0;
		endcase
	end

	// effective frame size
	logic [11:0] w_eff, w_last;
	logic [12:0] h_eff;
	logic [11:0] h_last;

	always_comb begin
		if (frame_width_q < 12'(lsh_pkg::MIN_DIM)) begin
			w_eff = 12'(lsh_pkg::MIN_DIM);
		end else if (frame_width_q > 12'(WCAP)) begin
			w_eff = 12'(WCAP);
		end else begin
			w_eff = frame_width_q;
		end
		if (frame_height_q < 13'(lsh_pkg::MIN_DIM)) begin
			h_eff = 13'(lsh_pkg::MIN_DIM);
		end else if (frame_height_q > 13'(lsh_pkg::MAX_HEIGHT)) begin
			h_eff = 13'(lsh_pkg::MAX_HEIGHT);
		end else begin
			h_eff = frame_height_q;
		end
		w_last = w_eff - 12'd1;
		h_last = 12'(h_eff - 13'd1);
	end

	// pipeline handshake
	logic       pix_fire;
	logic       valid_s1, valid_s2;
	logic       s1_adv, s2_adv, s1_free, s2_free, s3_free;
	logic [2:0] pend_s3, low_bit, pend_after;
	logic       res_take, emit, last_beat;

	assign res_take   = ~res_valid | res_ready;
	assign emit       = (|pend_s3) & res_take;
	assign low_bit    = pend_s3 & (~pend_s3 + 3'd1);
	assign pend_after = pend_s3 & ~low_bit;
	assign last_beat  = (pend_after == 3'd0);
	assign s3_free    = ~(|pend_s3) | (emit & last_beat);
	assign s2_adv     = valid_s2 & s3_free;
	assign s2_free    = ~valid_s2 | s3_free;
	assign s1_adv     = valid_s1 & s2_free;
	assign s1_free    = ~valid_s1 | s2_free;
	assign pix_ready  = s1_free;
	assign pix_fire   = pix_valid & pix_ready;

	// raster position of the next pixel
	logic [CW-1:0] col_q;
	logic [11:0]   row_q;
	logic          col_is_last, row_is_last;

	assign col_is_last = (32'(col_q) == 32'(w_last));
	assign row_is_last = (row_q == h_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pix_fire) begin
			if (col_is_last) begin
				col_q <= '0;
				row_q <= row_is_last ? 12'd0 : row_q + 12'd1;
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// stage 1: pixel and position, line store read in flight
	logic [PW-1:0] pix_s1;
	logic [CW-1:0] col_s1;
	logic [11:0]   row_s1;
	logic          clast_s1, rlast_s1;
	logic [2*PW-1:0] line_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_fire) begin
			pix_s1   <= pix;
			col_s1   <= col_q;
			row_s1   <= row_q;
			clast_s1 <= col_is_last;
			rlast_s1 <= row_is_last;
		end
	end

	// line storage: upper half two rows above, lower half one row above
	lsh_line_mem #(
		.DEPTH(MAX_WIDTH),
		.WIDTH(2 * PW)
	) u_line_mem (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (col_s1),
		.wdata ({line_rd[PW-1:0], pix_s1}),
		.re    (pix_fire),
		.raddr (col_q),
		.rdata (line_rd)
	);

	// stage 2: sliding window, column 2 newest
	logic [PW-1:0] w2_up_q, w2_mid_q, w2_dn_q;
	logic [PW-1:0] w1_up_q, w1_mid_q, w1_dn_q;
	logic [PW-1:0] w0_mid_q;
	logic [CW-1:0] col_s2;
	logic [11:0]   row_s2;
	logic          clast_s2, rlast_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_adv) begin
			valid_s2 <= 1'b1;
		end else if (s2_adv) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			w0_mid_q <= w1_mid_q;
			w1_up_q  <= w2_up_q;
			w1_mid_q <= w2_mid_q;
			w1_dn_q  <= w2_dn_q;
			w2_up_q  <= line_rd[2*PW-1:PW];
			w2_mid_q <= line_rd[PW-1:0];
			w2_dn_q  <= pix_s1;
			col_s2   <= col_s1;
			row_s2   <= row_s1;
			clast_s2 <= clast_s1;
			rlast_s2 <= rlast_s1;
		end
	end

	// stage 3: sharpened center and the set of beats this pixel owes
	logic [PW-1:0] sharp_s3;
	logic [CW-1:0] col_s3;
	logic [11:0]   row_s3;
	logic          clast_s3, rlast_s3;
	logic          row_zero, row_ge2, col_ge1, col_ge2;
	logic [2:0]    mask_next;

	assign row_zero  = (row_s2 == 12'd0);
	assign row_ge2   = (row_s2 >= 12'd2);
	assign col_ge1   = (col_s2 != '0);
	assign col_ge2   = (32'(col_s2) >= 32'd2);
	// bit 0 window center, bit 1 right border zero, bit 2 top or bottom row zero
	assign mask_next = {row_zero | (row_ge2 & rlast_s2), row_ge2 & clast_s2, row_ge2 & col_ge1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s3 <= '0;
		end else if (s2_adv) begin
			pend_s3 <= mask_next;
		end else if (emit) begin
			pend_s3 <= pend_after;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			sharp_s3 <= col_ge2 ? lsh_pkg::sharpen(w1_mid_q, w1_up_q, w1_dn_q, w0_mid_q, w2_mid_q)
				: '0;
			col_s3   <= col_s2;
			row_s3   <= row_s2;
			clast_s3 <= clast_s2;
			rlast_s3 <= rlast_s2;
		end
	end

	// output beat from the lowest pending entry
	lsh_pkg::res_t beat;
	logic          sel_main, sel_bot;

	assign sel_main = low_bit[0];
	assign sel_bot  = low_bit[2];

	always_comb begin
		beat           = '0;
		beat.out_row   = sel_bot ? row_s3 : row_s3 - 12'd1;
		beat.out_col   = sel_main ? 11'(col_s3 - CW'(1)) : 11'(col_s3);
		beat.out_c0    = sel_main ? sharp_s3[7:0] : 8'd0;
		beat.out_c1    = sel_main ? sharp_s3[15:8] : 8'd0;
		beat.out_c2    = sel_main ? sharp_s3[23:16] : 8'd0;
		beat.run_end   = last_beat;
		beat.frame_end = sel_bot & clast_s3 & rlast_s3;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (emit) begin
			res_valid <= 1'b1;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res <= beat;
		end
	end

`ifndef SYNTHESIS
	a_frame_end_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.frame_end |-> res.run_end)
		else $error("frame end beat without run end");

	a_edge_beat_at_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s3[1] |-> clast_s3)
		else $error("right border beat pending away from row end");

	a_s2_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !s3_free |=> valid_s2 && $stable(col_s2) && $stable(row_s2))
		else $error("window stage changed while stalled");
`endif

endmodule

[src/lsh_line_mem.sv]
module lsh_line_mem #(
	parameter int DEPTH = 2048,
	parameter int WIDTH = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
